// ===== rtl/fnps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnps_pkg
// Shared widths, register indexes and types for the four nearest point
// selector.
// ----------------------------------------------------------------------------
package fnps_pkg;

    localparam int COORD_BITS = 12;
    localparam int ID_BITS    = 10;
    localparam int RANK_COUNT = 4;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_Y = CFG_IDX_BITS'(1);

    // contents of one rank
    typedef struct packed {
        logic                 filled;
        logic [DIST_BITS-1:0] distance;
        logic [ID_BITS-1:0]   id;
    } t_rank;

    // scored point leaving the distance pipeline
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [DIST_BITS-1:0] distance;
        logic [ID_BITS-1:0]   id;
    } t_scored;

endpackage

`default_nettype wire

// ===== rtl/fnps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnps interfaces
// Point, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fnps_point_if;
    logic                           valid;
    logic                           ready;
    logic [fnps_pkg::COORD_BITS-1:0] point_x;
    logic [fnps_pkg::COORD_BITS-1:0] point_y;
    logic [fnps_pkg::ID_BITS-1:0]    point_id;
    logic                           last_point;

    modport source (output valid, point_x, point_y, point_id, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_id, last_point, output ready);
endinterface

interface fnps_result_if;
    logic                         valid;
    logic                         ready;
    logic [fnps_pkg::ID_BITS-1:0] nearest_id_0;
    logic [fnps_pkg::ID_BITS-1:0] nearest_id_1;
    logic [fnps_pkg::ID_BITS-1:0] nearest_id_2;
    logic [fnps_pkg::ID_BITS-1:0] nearest_id_3;
    logic                         found_0;
    logic                         found_1;
    logic                         found_2;
    logic                         found_3;

    modport source (output valid, nearest_id_0, nearest_id_1, nearest_id_2, nearest_id_3,
                    found_0, found_1, found_2, found_3, input ready);
    modport sink   (input valid, nearest_id_0, nearest_id_1, nearest_id_2, nearest_id_3,
                    found_0, found_1, found_2, found_3, output ready);
endinterface

interface fnps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fnps_pkg::CFG_IDX_BITS-1:0] index;
    logic [fnps_pkg::COORD_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fnps_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnps_dist
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module fnps_dist (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_adv,
    input  wire                             i_valid,
    input  wire [fnps_pkg::COORD_BITS-1:0]  i_point_x,
    input  wire [fnps_pkg::COORD_BITS-1:0]  i_point_y,
    input  wire [fnps_pkg::ID_BITS-1:0]     i_point_id,
    input  wire                             i_last_point,
    input  wire [fnps_pkg::COORD_BITS-1:0]  i_ref_x,
    input  wire [fnps_pkg::COORD_BITS-1:0]  i_ref_y,
    output fnps_pkg::t_scored               o_scored
);
    import fnps_pkg::*;

    logic                  r_v1, r_v2, r_v3;
    logic                  r_l1, r_l2, r_l3;
    logic [ID_BITS-1:0]    r_id1, r_id2, r_id3;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_BITS-1:0]    r_sqx, r_sqy;
    logic [DIST_BITS-1:0]  r_dist;
    logic [COORD_BITS-1:0] n_dx, n_dy;

    // absolute differences to the reference
    always_comb begin
        n_dx = (i_point_x >= i_ref_x) ? (i_point_x - i_ref_x) : (i_ref_x - i_point_x);
        n_dy = (i_point_y >= i_ref_y) ? (i_point_y - i_ref_y) : (i_ref_y - i_point_y);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_l1   <= i_last_point;
            r_id1  <= i_point_id;
            r_sqx  <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
            r_sqy  <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
            r_l2   <= r_l1;
            r_id2  <= r_id1;
            r_dist <= DIST_BITS'(r_sqx) + DIST_BITS'(r_sqy);
            r_l3   <= r_l2;
            r_id3  <= r_id2;
        end
    end

    assign o_scored = '{valid: r_v3, last: r_l3, distance: r_dist, id: r_id3};

endmodule

`default_nettype wire

// ===== rtl/fnps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnps_cell
// One rank of the sorted chain: takes a new point, or its upstream
// neighbour's contents when the point lands above it.
// ----------------------------------------------------------------------------
module fnps_cell (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    input  wire                            i_clear,
    input  wire [fnps_pkg::DIST_BITS-1:0]  i_dist,
    input  wire [fnps_pkg::ID_BITS-1:0]    i_id,
    input  fnps_pkg::t_rank                i_prev,
    input  wire                            i_prev_take,
    output logic                           o_take,
    output fnps_pkg::t_rank                o_rank,
    output fnps_pkg::t_rank                o_next
);
    import fnps_pkg::*;

    t_rank r_rank;
    t_rank n_rank;

    // strict compare: an equal distance stays behind
    assign o_take = i_valid && (!r_rank.filled || (i_dist < r_rank.distance));

    // shift down from neighbour, or load the new point at the first taking rank
    always_comb begin
        n_rank = r_rank;
        if (o_take) begin
            if (i_prev_take) begin
                n_rank = i_prev;
            end else begin
                n_rank = '{filled: 1'b1, distance: i_dist, id: i_id};
            end
        end
    end

    // rank register, only the filled flag is reset
    always_ff @(posedge i_clk) begin
        r_rank.distance <= n_rank.distance;
        r_rank.id       <= n_rank.id;
        if (!i_rst_n) begin
            r_rank.filled <= 1'b0;
        end else begin
            r_rank.filled <= i_clear ? 1'b0 : n_rank.filled;
        end
    end

    assign o_rank = r_rank;
    assign o_next = n_rank;

endmodule

`default_nettype wire

// ===== rtl/four_nearest_point_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_nearest_point_selector
// Keeps the four points of a list nearest to a reference position and
// reports their identifiers when the list ends.
// ----------------------------------------------------------------------------
// Takes one point per cycle. Each point passes a three-stage squared
// distance pipeline (differences, squares, sum) and then enters a chain of
// four rank cells; when the last point of a list reaches the chain, its
// ranks are copied into the result register. The input stalls only while a
// last point has reached the rank chain and the previous result is still
// not taken; otherwise requests flow back to back. Reference writes
// go through the configuration channel, index 0 for x and 1 for y, and take
// effect on points accepted afterwards; other indexes are ignored.
// ----------------------------------------------------------------------------
module four_nearest_point_selector (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fnps_point_if.sink   i_point,
    fnps_cfg_if.sink     i_cfg,
    fnps_result_if.source o_result
);
    import fnps_pkg::*;

    logic [COORD_BITS-1:0] r_ref_x, r_ref_y;
    logic                  w_adv;
    logic                  w_capture;
    t_scored               w_scored;
    t_rank                 w_rank [RANK_COUNT];
    t_rank                 w_next [RANK_COUNT];
    logic                  w_take [RANK_COUNT];
    logic                  r_out_valid;
    logic [ID_BITS-1:0]    r_out_id [RANK_COUNT];
    logic                  r_out_found [RANK_COUNT];

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_REF_X: r_ref_x <= i_cfg.data;
                CFG_REF_Y: r_ref_y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline advance: hold only when a finished list meets a full output
    assign w_adv     = !(w_scored.valid && w_scored.last && r_out_valid && !o_result.ready);
    assign w_capture = w_scored.valid && w_scored.last && w_adv;
    assign i_point.ready = w_adv;

    fnps_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (i_point.valid),
        .i_point_x   (i_point.point_x),
        .i_point_y   (i_point.point_y),
        .i_point_id  (i_point.point_id),
        .i_last_point(i_point.last_point),
        .i_ref_x     (r_ref_x),
        .i_ref_y     (r_ref_y),
        .o_scored    (w_scored)
    );

    // rank chain
    for (genvar k = 0; k < RANK_COUNT; k++) begin : g_rank
        t_rank w_prev;
        logic  w_prev_take;
        if (k == 0) begin : g_head
            assign w_prev      = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_body
            assign w_prev      = w_rank[k-1];
            assign w_prev_take = w_take[k-1];
        end
        fnps_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_scored.valid && w_adv),
            .i_clear    (w_capture),
            .i_dist     (w_scored.distance),
            .i_id       (w_scored.id),
            .i_prev     (w_prev),
            .i_prev_take(w_prev_take),
            .o_take     (w_take[k]),
            .o_rank     (w_rank[k]),
            .o_next     (w_next[k])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_capture) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            for (int k = 0; k < RANK_COUNT; k++) begin
                r_out_id[k]    <= w_next[k].filled ? w_next[k].id : '0;
                r_out_found[k] <= w_next[k].filled;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.nearest_id_0 = r_out_id[0];
    assign o_result.nearest_id_1 = r_out_id[1];
    assign o_result.nearest_id_2 = r_out_id[2];
    assign o_result.nearest_id_3 = r_out_id[3];
    assign o_result.found_0      = r_out_found[0];
    assign o_result.found_1      = r_out_found[1];
    assign o_result.found_2      = r_out_found[2];
    assign o_result.found_3      = r_out_found[3];

endmodule

`default_nettype wire
